// ===== rtl/core/tgf_pkg.sv =====
`default_nettype none

package tgf_pkg;

    // Field widths of the stream payloads
    localparam int TS_W      = 64;
    localparam int PL_W      = 32;
    localparam int LEN_W     = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // One stored entry: {length, handle, time}
    localparam int ENT_W      = TS_W + PL_W + LEN_W;
    localparam int IN_TDATA_W = ((ENT_W + 7) / 8) * 8;

    // Result bits below the occupancy field: status, found, time, handle, length
    localparam int RES_FIX_W = 2 + TS_W + PL_W + LEN_W;

    // Signed difference of two times, with room for the window adds
    localparam int DIFF_W = TS_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_STALE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FUTURE = 1'b1;

    localparam logic [CFG_W-1:0] STALE_RESET  = 32'd1000;
    localparam logic [CFG_W-1:0] FUTURE_RESET = 32'd5000;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_GET   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DROP_RD,
        S_DROP_DIFF,
        S_DROP_CHK,
        S_MARK_RD,
        S_MARK_DIFF,
        S_MARK_CHK,
        S_GET_RD,
        S_GET_CHK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec_put;
        logic exec_flush;
        logic rd_en;
        logic rd_mark;
        logic load_diff;
        logic drop;
        logic mark;
        logic pop;
        logic fail;
        logic push;
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic all_peeked;
        logic peeked_any;
        logic drop_ok;
        logic due;
        logic match;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/timestamp_gated_fifo.sv =====
// Timestamp-gated entry FIFO, paced by a playback clock.
// Slave stream: one item is a command in s_tuser (put, peek, get, flush) and
// {length, handle, time} in s_tdata. Master stream: one result per item.
// Configuration channel: index 0 writes the stale window, index 1 the future
// window; write only while the block is idle. cfg_ready is always high.
// Items are processed one at a time; s_tready is high only while idle.
// Put and flush update the FIFO; get reads the head if an entry is peeked
// and pops it on a time match; peek drops heads while nothing is peeked,
// then judges the next entry. The drop loop is bounded by the single read port
// of the entry RAM: read, form the difference, then judge.
// The result sits in an output register, so the next item is accepted
// as soon as it is loaded, even if the receiver stalls; a further result
// holds in the controller until the output register is taken.
// Reset (synchronous, active low) empties the FIFO, clears the output
// valid and restores the windows to 1000 and 5000. Entry RAM contents are
// not cleared; they are only read behind the entry count.
`default_nettype none

module timestamp_gated_fifo #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: timestamp[63:0], payload[95:64], payload_length[103:96]
    input  wire logic [tgf_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]                         i_s_tuser,
    // master stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: status, found, entry_time_out[64], payload_out[32], length_out[8],
    //        occupancy, zero fill
    output logic [((tgf_pkg::RES_FIX_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tgf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tgf_pkg::CFG_W-1:0]          i_cfg_data
);

    import tgf_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // Take writes at any time; the user keeps them to idle periods
    assign o_cfg_ready = 1'b1;

    tgf_ctrl u_tgf_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    tgf_dp #(
        .DEPTH (DEPTH)
    ) u_tgf_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tgf_ram.sv =====
`default_nettype none

module tgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tgf_ctrl.sv =====
`default_nettype none

module tgf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire tgf_pkg::t_stat i_stat,
    output tgf_pkg::t_ctrl      o_ctrl
);

    import tgf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready     = 1'b1;
                o_ctrl.load_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_PUT: begin
                        o_ctrl.exec_put = 1'b1;
                        n_state         = S_DONE;
                    end
                    CMD_FLUSH: begin
                        o_ctrl.exec_flush = 1'b1;
                        n_state           = S_DONE;
                    end
                    CMD_PEEK: n_state = S_DROP_RD;
                    CMD_GET:  n_state = S_GET_RD;
                endcase
            end
            // Drop stale or far-ahead heads, one per pass, while nothing is peeked
            S_DROP_RD: begin
                if (!i_stat.empty && !i_stat.peeked_any) begin
                    o_ctrl.rd_en = 1'b1;
                    n_state      = S_DROP_DIFF;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            S_DROP_DIFF: begin
                o_ctrl.load_diff = 1'b1;
                n_state          = S_DROP_CHK;
            end
            S_DROP_CHK: begin
                if (i_stat.drop_ok) begin
                    o_ctrl.drop = 1'b1;
                    n_state     = S_DROP_RD;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                if (!i_stat.all_peeked) begin
                    o_ctrl.rd_en   = 1'b1;
                    o_ctrl.rd_mark = 1'b1;
                    n_state        = S_MARK_DIFF;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MARK_DIFF: begin
                o_ctrl.load_diff = 1'b1;
                n_state          = S_MARK_CHK;
            end
            S_MARK_CHK: begin
                o_ctrl.mark = i_stat.due;
                n_state     = S_DONE;
            end
            S_GET_RD: begin
                if (i_stat.peeked_any) begin
                    o_ctrl.rd_en = 1'b1;
                    n_state      = S_GET_CHK;
                end else begin
                    o_ctrl.fail = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_GET_CHK: begin
                o_ctrl.pop  = i_stat.match;
                o_ctrl.fail = !i_stat.match;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.push = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tgf_dp.sv =====
`default_nettype none

module tgf_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire tgf_pkg::t_ctrl                         i_ctrl,
    output tgf_pkg::t_stat                              o_stat,
    input  wire logic [tgf_pkg::IN_TDATA_W-1:0]         i_s_tdata,
    input  wire logic [1:0]                             i_s_tuser,
    input  wire logic                                   i_cfg_valid,
    input  wire logic [tgf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [tgf_pkg::CFG_W-1:0]              i_cfg_data,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    output logic [((tgf_pkg::RES_FIX_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);

    import tgf_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int SW      = AW + 1;
    localparam int OUT_W   = RES_FIX_W + CW;
    localparam int OUT_TDW = ((OUT_W + 7) / 8) * 8;

    // Latched item
    t_cmd               r_cmd;
    logic [TS_W-1:0]    r_ts;
    logic [PL_W-1:0]    r_pl;
    logic [LEN_W-1:0]   r_len;

    logic [CFG_W-1:0]   r_stale;
    logic [CFG_W-1:0]   r_future;

    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_peeked;

    logic signed [DIFF_W-1:0] r_diff;
    logic [TS_W-1:0]    r_ent_time;

    logic               r_status;
    logic               r_found;
    logic [TS_W-1:0]    r_rtime;
    logic [PL_W-1:0]    r_rpl;
    logic [LEN_W-1:0]   r_rlen;

    logic               r_out_valid;
    logic [OUT_TDW-1:0] r_out_data;

    logic               full;
    logic [AW-1:0]      head_next;
    logic [AW-1:0]      tail_next;
    logic [SW-1:0]      mark_sum;
    logic [AW-1:0]      mark_addr;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [ENT_W-1:0]   rd_data;
    logic [TS_W-1:0]    rd_time;
    logic signed [DIFF_W-1:0] diff_calc;
    logic signed [DIFF_W-1:0] sum_future;
    logic signed [DIFF_W-1:0] sum_stale;
    logic signed [DIFF_W-1:0] stale_ext;

    assign full      = (r_count == CW'(DEPTH));
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign mark_sum  = SW'(r_head) + SW'(r_peeked);
    assign mark_addr = (mark_sum >= SW'(DEPTH)) ? AW'(mark_sum - SW'(DEPTH)) : AW'(mark_sum);
    assign rd_addr   = i_ctrl.rd_mark ? mark_addr : r_head;
    assign wr_en     = i_ctrl.exec_put && !full;
    assign rd_time   = rd_data[TS_W-1:0];

    tgf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_tgf_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_tail),
        .i_wdata ({r_len, r_pl, r_ts}),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Clock minus entry time, exact in DIFF_W bits
    assign diff_calc  = $signed({{2{r_ts[TS_W-1]}}, r_ts})
                      - $signed({{2{rd_time[TS_W-1]}}, rd_time});
    assign stale_ext  = $signed({{(DIFF_W - CFG_W){1'b0}}, r_stale});
    assign sum_future = r_diff + $signed({{(DIFF_W - CFG_W){1'b0}}, r_future});
    assign sum_stale  = r_diff + stale_ext;

    always_comb begin
        o_stat            = '0;
        o_stat.cmd        = r_cmd;
        o_stat.empty      = (r_count == '0);
        o_stat.all_peeked = (r_peeked == r_count);
        o_stat.peeked_any = (r_peeked != '0);
        // Too old: behind by more than the stale window; too far ahead: lead over future window
        o_stat.drop_ok    = (r_diff > stale_ext) || sum_future[DIFF_W-1];
        // Due: distance strictly below the stale window on either side
        o_stat.due        = (r_diff < stale_ext) && !sum_stale[DIFF_W-1] && (sum_stale != '0);
        o_stat.match      = (rd_time == r_ts);
        o_stat.out_busy   = r_out_valid && !i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd <= t_cmd'(i_s_tuser);
            r_ts  <= i_s_tdata[TS_W-1:0];
            r_pl  <= i_s_tdata[TS_W +: PL_W];
            r_len <= i_s_tdata[TS_W + PL_W +: LEN_W];
        end
        if (i_ctrl.load_diff) begin
            r_diff     <= diff_calc;
            r_ent_time <= rd_time;
        end
        if (i_ctrl.push) begin
            r_out_data <= OUT_TDW'({r_count, r_rlen, r_rpl, r_rtime, r_found, r_status});
        end
        priority if (i_ctrl.load_in) begin
            r_status <= 1'b0;
            r_found  <= 1'b0;
            r_rtime  <= '0;
            r_rpl    <= '0;
            r_rlen   <= '0;
        end else if (i_ctrl.exec_put && full) begin
            r_status <= 1'b1;
        end else if (i_ctrl.fail) begin
            r_status <= 1'b1;
        end else if (i_ctrl.mark) begin
            r_found <= 1'b1;
            r_rtime <= r_ent_time;
        end else if (i_ctrl.pop) begin
            r_rtime <= rd_time;
            r_rpl   <= rd_data[TS_W +: PL_W];
            r_rlen  <= rd_data[TS_W + PL_W +: LEN_W];
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale     <= STALE_RESET;
            r_future    <= FUTURE_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_peeked    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STALE:  r_stale  <= i_cfg_data;
                    REG_FUTURE: r_future <= i_cfg_data;
                endcase
            end
            priority if (i_ctrl.exec_flush) begin
                r_head   <= '0;
                r_tail   <= '0;
                r_count  <= '0;
                r_peeked <= '0;
            end else if (wr_en) begin
                r_tail  <= tail_next;
                r_count <= r_count + 1'b1;
            end else if (i_ctrl.drop) begin
                r_head  <= head_next;
                r_count <= r_count - 1'b1;
            end else if (i_ctrl.pop) begin
                r_head   <= head_next;
                r_count  <= r_count - 1'b1;
                r_peeked <= r_peeked - 1'b1;
            end else if (i_ctrl.mark) begin
                r_peeked <= r_peeked + 1'b1;
            end else begin
            end
            if (i_ctrl.push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/tgf_checker.sv =====
`default_nettype none

module tgf_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_tvalid,
    input wire logic                                o_s_tready,
    input wire logic                                o_m_tvalid,
    input wire logic                                i_m_tready,
    input wire logic [((tgf_pkg::RES_FIX_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);

    import tgf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic          res_status;
    logic          res_found;
    logic [CW-1:0] res_occ;

    assign res_status = o_m_tdata[0];
    assign res_found  = o_m_tdata[1];
    assign res_occ    = o_m_tdata[RES_FIX_W +: CW];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // One item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while busy");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res_found |-> !res_status)
        else $error("found result reports failure");

    a_found_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res_found |-> res_occ != '0)
        else $error("found entry in empty FIFO");

endmodule

bind timestamp_gated_fifo tgf_checker #(
    .DEPTH (DEPTH)
) u_tgf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
